// File: design/qte_pkg.sv
// shared types, widths and constant tables for the quaternion to euler block
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN          = 24;
  localparam int VW               = 34;   // atan2 argument width
  localparam int CW               = 44;   // cordic x/y datapath width
  localparam int ZW               = 28;   // angle accumulator, 2^-24 rad
  localparam int SQ_N             = 32;   // integer square root stages
  localparam int FIFO_DEPTH       = 4;
  localparam int NORM_TOP         = 40;   // larger magnitude lands in [2^40, 2^41)
  localparam logic signed [ZW-1:0] HALF_PI_I = 28'sd26353589;
  localparam logic signed [17:0]   OUT_PI      = 18'sd25736;
  localparam logic signed [17:0]   OUT_HALF_PI = 18'sd12868;

  typedef struct packed {
    logic signed [VW-1:0] roll_y;
    logic signed [VW-1:0] roll_x;
    logic signed [VW-1:0] yaw_y;
    logic signed [VW-1:0] yaw_x;
    logic signed [VW-1:0] pa;
    logic [32:0]          n2;
    logic                 zero;
  } item_t;

  typedef struct packed {
    logic signed [VW-1:0] roll_y;
    logic signed [VW-1:0] roll_x;
    logic signed [VW-1:0] yaw_y;
    logic signed [VW-1:0] yaw_x;
    logic signed [VW-1:0] pitch_y;
  } side_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] msb_pos(input logic [VW-1:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < VW; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// File: design/qte_if.sv
// valid/ready channel interfaces for quaternion beats and angle beats
`timescale 1ns / 1ps
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] qx;
  logic signed [15:0] qy;
  logic signed [15:0] qz;
  logic signed [15:0] qw;
  modport source (output valid, qx, qy, qz, qw, input ready);
  modport sink   (input valid, qx, qy, qz, qw, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;
  logic               zero_norm;
  modport source (output valid, roll, pitch, yaw, zero_norm, input ready);
  modport sink   (input valid, roll, pitch, yaw, zero_norm, output ready);
endinterface

// File: design/quaternion_to_euler_zyx.sv
// data path: front end registers, then the queue, then the angle pipeline,
//   in which the 32 square root stages are the largest part
// throughput: one beat per cycle; the whole angle pipeline halts while a result waits
// reset: synchronous active-low rst_n clears valids and queue pointers; no clearing pass
`timescale 1ns / 1ps
module quaternion_to_euler_zyx #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_if,
  qte_out_if.source out_if
);

  qte_pkg::item_t f_item, q_item;
  logic           f_vld, f_rdy, q_vld, q_rdy;

  qte_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if),
    .f_item(f_item), .f_vld(f_vld), .f_rdy(f_rdy)
  );

  qte_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_item(f_item), .wr_vld(f_vld), .wr_rdy(f_rdy),
    .rd_item(q_item), .rd_vld(q_vld), .rd_rdy(q_rdy)
  );

  qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .b_item(q_item), .b_vld(q_vld), .b_rdy(q_rdy),
    .out_if(out_if)
  );

`ifndef NO_ASSERTIONS
  a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.zero_norm |->
      out_if.roll == '0 && out_if.pitch == '0 && out_if.yaw == '0)
    else $error("zero quaternion gave nonzero angles");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.pitch <= 15'sd12868 && out_if.pitch >= -15'sd12868)
    else $error("pitch beyond half pi");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.roll <= 16'sd25736 && out_if.roll >= -16'sd25736)
    else $error("roll beyond pi");
`endif

endmodule

// File: design/qte_front.sv
// front end: squares and cross products, then the atan2 argument sums
`timescale 1ns / 1ps
module qte_front (
  input  logic              clk,
  input  logic              rst_n,
  qte_in_if.sink            in_if,
  output qte_pkg::item_t    f_item,
  output logic              f_vld,
  input  logic              f_rdy
);

  logic               en;
  logic               f1_vld_r, f2_vld_r;
  logic signed [31:0] xx_r, yy_r, zz_r, ww_r, wx_r, yz_r, wy_r, zx_r, wz_r, xy_r;
  qte_pkg::item_t     f2_r;
  qte_pkg::item_t     item_nxt;
  logic signed [34:0] n2_w;

  assign en          = !f2_vld_r || f_rdy;
  assign in_if.ready = en;
  assign f_vld       = f2_vld_r;
  assign f_item      = f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_if.valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= in_if.qx * in_if.qx;
      yy_r <= in_if.qy * in_if.qy;
      zz_r <= in_if.qz * in_if.qz;
      ww_r <= in_if.qw * in_if.qw;
      wx_r <= in_if.qw * in_if.qx;
      yz_r <= in_if.qy * in_if.qz;
      wy_r <= in_if.qw * in_if.qy;
      zx_r <= in_if.qz * in_if.qx;
      wz_r <= in_if.qw * in_if.qz;
      xy_r <= in_if.qx * in_if.qy;
      f2_r <= item_nxt;
    end
  end

  always_comb begin
    n2_w = 35'(xx_r) + 35'(yy_r) + 35'(zz_r) + 35'(ww_r);
    item_nxt.n2     = n2_w[32:0];
    item_nxt.zero   = (n2_w == '0);
    item_nxt.roll_y = 34'((35'(wx_r) + 35'(yz_r)) <<< 1);
    item_nxt.roll_x = 34'(n2_w - ((35'(xx_r) + 35'(yy_r)) <<< 1));
    item_nxt.yaw_y  = 34'((35'(wz_r) + 35'(xy_r)) <<< 1);
    item_nxt.yaw_x  = 34'(n2_w - ((35'(yy_r) + 35'(zz_r)) <<< 1));
    item_nxt.pa     = 34'((35'(wy_r) - 35'(zx_r)) <<< 1);
  end

endmodule

// File: design/qte_fifo.sv
// short queue between the front end and the angle pipeline
`timescale 1ns / 1ps
module qte_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  qte_pkg::item_t wr_item,
  input  logic           wr_vld,
  output logic           wr_rdy,
  output qte_pkg::item_t rd_item,
  output logic           rd_vld,
  input  logic           rd_rdy
);

  localparam int PW = $clog2(qte_pkg::FIFO_DEPTH);

  qte_pkg::item_t mem_r [qte_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;
  logic           push, pop;

  assign wr_rdy  = (cnt_r != (PW+1)'(qte_pkg::FIFO_DEPTH));
  assign rd_vld  = (cnt_r != '0);
  assign rd_item = mem_r[rp_r];
  assign push    = wr_vld && wr_rdy;
  assign pop     = rd_vld && rd_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

// File: design/qte_cordic.sv
// pipelined vectoring cordic lane: atan2(y, x) in 2^-24 rad
`timescale 1ns / 1ps
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qte_pkg::VW-1:0] in_y,
  input  logic signed [qte_pkg::VW-1:0] in_x,
  output logic signed [qte_pkg::ZW-1:0] z_out
);

  localparam int CW = qte_pkg::CW;
  localparam int VW = qte_pkg::VW;
  localparam int ZW = qte_pkg::ZW;

  logic [VW-1:0]        ax, ay;
  logic signed [CW-1:0] xa_r, ya_r, xb_r, yb_r, xc_r, yc_r;
  logic [VW-1:0]        ma_r;
  logic [5:0]           sh_r;
  logic                 za_r, zb_r, zc_r;
  logic signed [CW-1:0] xs_r [STEPS+1];
  logic signed [CW-1:0] ys_r [STEPS+1];
  logic signed [ZW-1:0] zs_r [STEPS+1];
  logic                 zf_r [STEPS+1];

  assign ax = in_x[VW-1] ? VW'(-in_x) : VW'(in_x);
  assign ay = in_y[VW-1] ? VW'(-in_y) : VW'(in_y);

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= CW'(in_x);
      ya_r <= CW'(in_y);
      ma_r <= (ax > ay) ? ax : ay;
      za_r <= (in_x == '0) && (in_y == '0);
      // normalise the larger magnitude up to bit 40
      sh_r <= 6'(7'(qte_pkg::NORM_TOP) - {1'b0, qte_pkg::msb_pos(ma_r)});
      xb_r <= xa_r;
      yb_r <= ya_r;
      zb_r <= za_r;
      xc_r <= xb_r <<< sh_r;
      yc_r <= yb_r <<< sh_r;
      zc_r <= zb_r;
      zf_r[0] <= zc_r;
      // quarter turn into the right half plane
      if (xc_r[CW-1]) begin
        if (!yc_r[CW-1]) begin
          xs_r[0] <= yc_r;
          ys_r[0] <= -xc_r;
          zs_r[0] <= qte_pkg::HALF_PI_I;
        end else begin
          xs_r[0] <= -yc_r;
          ys_r[0] <= xc_r;
          zs_r[0] <= -qte_pkg::HALF_PI_I;
        end
      end else begin
        xs_r[0] <= xc_r;
        ys_r[0] <= yc_r;
        zs_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i+1] <= zf_r[i];
        if (!ys_r[i][CW-1]) begin
          xs_r[i+1] <= xs_r[i] + (ys_r[i] >>> i);
          ys_r[i+1] <= ys_r[i] - (xs_r[i] >>> i);
          zs_r[i+1] <= zs_r[i] + qte_pkg::atan_val(i);
        end else begin
          xs_r[i+1] <= xs_r[i] - (ys_r[i] >>> i);
          ys_r[i+1] <= ys_r[i] + (xs_r[i] >>> i);
          zs_r[i+1] <= zs_r[i] - qte_pkg::atan_val(i);
        end
      end
    end
  end

  assign z_out = zf_r[STEPS] ? '0 : zs_r[STEPS];

endmodule

// File: design/qte_back.sv
// back end: pitch cosine by square root, three cordic lanes, rounding and clamp
`timescale 1ns / 1ps
module qte_back #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  qte_pkg::item_t b_item,
  input  logic           b_vld,
  output logic           b_rdy,
  qte_out_if.source      out_if
);

  localparam int VW   = qte_pkg::VW;
  localparam int ZW   = qte_pkg::ZW;
  localparam int SQ_N = qte_pkg::SQ_N;
  localparam int LAT  = 2 + SQ_N + 4 + CORDIC_STEPS + 1;

  logic               en;
  logic [LAT-1:0]     vld_r, zf_r;
  logic [32:0]        amag, ua_w, ub_w;
  logic [30:0]        s0_ua_r, s0_ub_r, s1_ua_r;
  logic               s0_neg_r, s1_neg_r;
  logic [63:0]        s1_prod_r;
  qte_pkg::side_t     s0_side_r, s1_side_r;
  qte_pkg::side_t     sq_side_r [SQ_N];
  logic [63:0]        sq_v_r [SQ_N];
  logic [63:0]        sq_q_r [SQ_N];
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;

  assign en    = !vld_r[LAT-1] || out_if.ready;
  assign b_rdy = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], b_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) zf_r <= {zf_r[LAT-2:0], b_item.zero};
  end

  // pitch: scale, clamp |a| to n2
  always_comb begin
    amag = b_item.pa[VW-1] ? 33'(-b_item.pa) : 33'(b_item.pa);
    if (b_item.n2 >= 33'h0_8000_0000) begin
      ua_w = amag >> 2;
      ub_w = b_item.n2 >> 2;
    end else begin
      ua_w = amag;
      ub_w = b_item.n2;
    end
    if (ua_w > ub_w) ua_w = ub_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ua_r          <= ua_w[30:0];
      s0_ub_r          <= ub_w[30:0];
      s0_neg_r         <= b_item.pa[VW-1];
      s0_side_r.roll_y <= b_item.roll_y;
      s0_side_r.roll_x <= b_item.roll_x;
      s0_side_r.yaw_y  <= b_item.yaw_y;
      s0_side_r.yaw_x  <= b_item.yaw_x;
      s0_side_r.pitch_y <= '0;
      s1_prod_r <= 64'((32'(s0_ub_r) - 32'(s0_ua_r)) * (32'(s0_ub_r) + 32'(s0_ua_r)));
      s1_ua_r   <= s0_ua_r;
      s1_neg_r  <= s0_neg_r;
      s1_side_r <= s0_side_r;
    end
  end

  // restoring square root, two radicand bits a stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] v_in, q_in, t;
    qte_pkg::side_t side_in;
    if (k == 0) begin : g_first
      assign v_in = s1_prod_r;
      assign q_in = '0;
      always_comb begin
        side_in         = s1_side_r;
        side_in.pitch_y = s1_neg_r ? -VW'(s1_ua_r) : VW'(s1_ua_r);
      end
    end else begin : g_next
      assign v_in    = sq_v_r[k-1];
      assign q_in    = sq_q_r[k-1];
      assign side_in = sq_side_r[k-1];
    end
    assign t = q_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[k] <= side_in;
        if (v_in >= t) begin
          sq_v_r[k] <= v_in - t;
          sq_q_r[k] <= (q_in >> 1) + BIT;
        end else begin
          sq_v_r[k] <= v_in;
          sq_q_r[k] <= q_in >> 1;
        end
      end
    end
  end

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en),
    .in_y(sq_side_r[SQ_N-1].roll_y), .in_x(sq_side_r[SQ_N-1].roll_x),
    .z_out(z_roll)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en),
    .in_y(sq_side_r[SQ_N-1].pitch_y), .in_x(VW'(sq_q_r[SQ_N-1][31:0])),
    .z_out(z_pitch)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en),
    .in_y(sq_side_r[SQ_N-1].yaw_y), .in_x(sq_side_r[SQ_N-1].yaw_x),
    .z_out(z_yaw)
  );

  function automatic logic signed [17:0] to_out(input logic signed [ZW-1:0] z,
                                                input logic signed [17:0] lim);
    logic signed [ZW:0] t;
    logic signed [17:0] r;
    t = (ZW+1)'(z) + (ZW+1)'(1024);
    r = 18'(t >>> 11);
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= 16'(to_out(z_roll, qte_pkg::OUT_PI));
      pitch_r <= 15'(to_out(z_pitch, qte_pkg::OUT_HALF_PI));
      yaw_r   <= 16'(to_out(z_yaw, qte_pkg::OUT_PI));
    end
  end

  assign out_if.valid     = vld_r[LAT-1];
  assign out_if.roll      = roll_r;
  assign out_if.pitch     = pitch_r;
  assign out_if.yaw       = yaw_r;
  assign out_if.zero_norm = zf_r[LAT-1];

endmodule
